@@ hw/rtl/aesp_pkg.sv @@
// Shared types and constants of the ANSI escape sequence parser.
package aesp_pkg;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] CSI_BYTE  = 8'h5B;   // '['
  localparam logic [7:0] SEMI_BYTE = 8'h3B;   // ';'
  localparam logic [7:0] ZERO_CHAR = 8'h30;   // '0'
  localparam logic [7:0] NINE_CHAR = 8'h39;   // '9'
  localparam logic [15:0] PARAM_MAX = 16'hFFFF;

  // Result kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  // Command codes.
  localparam logic [3:0] CMD_UP      = 4'd0;
  localparam logic [3:0] CMD_DOWN    = 4'd1;
  localparam logic [3:0] CMD_RIGHT   = 4'd2;
  localparam logic [3:0] CMD_LEFT    = 4'd3;
  localparam logic [3:0] CMD_NEXTLN  = 4'd4;
  localparam logic [3:0] CMD_PREVLN  = 4'd5;
  localparam logic [3:0] CMD_POS     = 4'd6;
  localparam logic [3:0] CMD_SAVE    = 4'd7;
  localparam logic [3:0] CMD_RESTORE = 4'd8;
  localparam logic [3:0] CMD_ERASE_D = 4'd9;
  localparam logic [3:0] CMD_ERASE_L = 4'd10;
  localparam logic [3:0] CMD_INSERT  = 4'd11;
  localparam logic [3:0] CMD_ATTR    = 4'd12;

  // What an accepted byte asks for.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_TEXT  = 2'd1,
    ACT_CMD   = 2'd2,
    ACT_FLUSH = 2'd3
  } act_t;

  // Source of the next result loaded into the output register.
  typedef enum logic [1:0] {
    SRC_IN   = 2'd0,
    SRC_CMD  = 2'd1,
    SRC_RAM  = 2'd2,
    SRC_PEND = 2'd3
  } src_t;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic idx_inc;
    logic out_load;
    src_t out_src;
  } ctrl_cmd_t;

  typedef struct packed {
    act_t action;
    logic out_free;
    logic fl_done;
    logic trail;
  } dp_status_t;

endpackage

@@ hw/rtl/aesp_if.sv @@
// Channel interfaces of the ANSI escape sequence parser.
interface aesp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface aesp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  text_byte;
  logic [3:0]  command_code;
  logic        has_first;
  logic        has_second;
  logic [15:0] first_value;
  logic [15:0] second_value;
  logic        last_of_run;

  modport source (output valid, output item_kind, output text_byte, output command_code,
                  output has_first, output has_second, output first_value,
                  output second_value, output last_of_run, input ready);
  modport sink   (input valid, input item_kind, input text_byte, input command_code,
                  input has_first, input has_second, input first_value,
                  input second_value, input last_of_run, output ready);
endinterface

@@ hw/rtl/aesp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module aesp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/aesp_ctrl.sv @@
// Controller state machine of the ANSI escape sequence parser.
module aesp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aesp_pkg::dp_status_t   sts,
  output aesp_pkg::ctrl_cmd_t    cmd
);
  import aesp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_EMIT  = 4'b0100,
    S_TRAIL = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          case (sts.action)
            ACT_TEXT: begin
              cmd.out_load = 1'b1;
              cmd.out_src  = SRC_IN;
            end
            ACT_CMD: begin
              cmd.out_load = 1'b1;
              cmd.out_src  = SRC_CMD;
            end
            ACT_FLUSH: begin
              state_nxt = S_READ;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_RAM;
          if (sts.fl_done) begin
            state_nxt = sts.trail ? S_TRAIL : S_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_TRAIL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = SRC_PEND;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/aesp_dp.sv @@
// Datapath of the ANSI escape sequence parser: sequence buffer, parameter
// accumulators, byte classification and the output register.
module aesp_dp #(
  parameter int SEQ_BUFFER_LEN = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_byte,
  input  aesp_pkg::ctrl_cmd_t  cmd,
  output aesp_pkg::dp_status_t sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_kind,
  output logic [7:0]           out_text,
  output logic [3:0]           out_code,
  output logic                 out_h1,
  output logic                 out_h2,
  output logic [15:0]          out_v1,
  output logic [15:0]          out_v2,
  output logic                 out_last
);
  import aesp_pkg::*;

  localparam int AW = $clog2(SEQ_BUFFER_LEN);
  localparam int LW = $clog2(SEQ_BUFFER_LEN + 1);
  localparam logic [LW-1:0] LEN_ZERO = '0;
  localparam logic [LW-1:0] LEN_ONE  = LW'(1);
  localparam logic [LW-1:0] LEN_TWO  = LW'(2);
  localparam logic [LW-1:0] LEN_FULL = LW'(SEQ_BUFFER_LEN);

  // Sequence state.
  logic [LW-1:0] len_r, len_nxt;
  logic          sep_r, sep_nxt;
  logic          h1_r, h1_nxt;
  logic          h2_r, h2_nxt;
  logic [15:0]   v1_r, v1_nxt;
  logic [15:0]   v2_r, v2_nxt;

  // Flush replay state.
  logic [AW-1:0] fl_idx_r, fl_idx_nxt;
  logic [AW-1:0] fl_end_r, fl_end_nxt;
  logic          trail_r, trail_nxt;
  logic [7:0]    pend_r, pend_nxt;

  // Output register.
  logic          ov_r, ov_nxt;
  logic          ok_r, ok_nxt;
  logic [7:0]    ot_r, ot_nxt;
  logic [3:0]    oc_r, oc_nxt;
  logic          oh1_r, oh1_nxt;
  logic          oh2_r, oh2_nxt;
  logic [15:0]   ov1_r, ov1_nxt;
  logic [15:0]   ov2_r, ov2_nxt;
  logic          ol_r, ol_nxt;

  logic          is_esc, is_digit, is_semi, is_csi;
  logic          allow_nodig, allow_dig, allow_sep, fin_ok;
  logic [3:0]    fin_code;
  logic          pfx_ok, append;
  logic          trail_c;
  act_t          action;
  logic [15:0]   cur_v, sat_v;
  logic [19:0]   prod;
  logic [LW-1:0] len_m1;
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic          out_free;

  assign is_esc   = (in_byte == ESC_BYTE);
  assign is_semi  = (in_byte == SEMI_BYTE);
  assign is_csi   = (in_byte == CSI_BYTE);
  assign is_digit = (in_byte >= ZERO_CHAR) && (in_byte <= NINE_CHAR);

  // Final letters and the parameter shapes that each one accepts.
  always_comb begin
    fin_code    = CMD_UP;
    allow_nodig = 1'b0;
    allow_dig   = 1'b0;
    allow_sep   = 1'b0;
    case (in_byte)
      "A": begin fin_code = CMD_UP;      allow_nodig = 1'b1; allow_dig = 1'b1; end
      "B": begin fin_code = CMD_DOWN;    allow_nodig = 1'b1; allow_dig = 1'b1; end
      "C": begin fin_code = CMD_RIGHT;   allow_nodig = 1'b1; allow_dig = 1'b1; end
      "D": begin fin_code = CMD_LEFT;    allow_nodig = 1'b1; allow_dig = 1'b1; end
      "E": begin fin_code = CMD_NEXTLN;  allow_nodig = 1'b1; allow_dig = 1'b1; end
      "F": begin fin_code = CMD_PREVLN;  allow_nodig = 1'b1; allow_dig = 1'b1; end
      "H": begin fin_code = CMD_POS;     allow_nodig = 1'b1; allow_sep = 1'b1; end
      "f": begin fin_code = CMD_POS;     allow_sep = 1'b1; end
      "s": begin fin_code = CMD_SAVE;    allow_nodig = 1'b1; end
      "u": begin fin_code = CMD_RESTORE; allow_nodig = 1'b1; end
      "J": begin fin_code = CMD_ERASE_D; allow_nodig = 1'b1; allow_dig = 1'b1; end
      "K": begin fin_code = CMD_ERASE_L; allow_nodig = 1'b1; allow_dig = 1'b1; end
      "L": begin fin_code = CMD_INSERT;  allow_nodig = 1'b1; allow_dig = 1'b1; end
      "m": begin
        fin_code    = CMD_ATTR;
        allow_nodig = 1'b1;
        allow_dig   = 1'b1;
        allow_sep   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign fin_ok = sep_r ? allow_sep : (h1_r ? allow_dig : allow_nodig);

  // Right after ESC only '[' continues; after that digits and one semicolon.
  assign pfx_ok = (len_r == LEN_ONE) ? is_csi : (is_digit || (is_semi && !sep_r));

  always_comb begin
    action  = ACT_NONE;
    trail_c = 1'b0;
    append  = 1'b0;
    if (is_esc) begin
      action = (len_r >= LEN_TWO) ? ACT_FLUSH : ACT_NONE;
    end else if (len_r == LEN_ZERO) begin
      action = ACT_TEXT;
    end else if (len_r == LEN_FULL) begin
      action  = ACT_FLUSH;
      trail_c = 1'b1;
    end else if (pfx_ok) begin
      append = 1'b1;
    end else if ((len_r != LEN_ONE) && fin_ok) begin
      action = ACT_CMD;
    end else if (len_r == LEN_ONE) begin
      action = ACT_TEXT;
    end else begin
      action  = ACT_FLUSH;
      trail_c = 1'b1;
    end
  end

  // Saturating decimal accumulate: v * 10 + digit.
  assign cur_v = sep_r ? v2_r : v1_r;
  assign prod  = 20'({cur_v, 3'b000}) + 20'({cur_v, 1'b0}) + 20'(in_byte[3:0]);
  assign sat_v = (prod > 20'(PARAM_MAX)) ? PARAM_MAX : prod[15:0];

  assign len_m1 = len_r - LEN_ONE;
  assign ram_we = cmd.accept && append;

  always_comb begin
    len_nxt    = len_r;
    sep_nxt    = sep_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    v1_nxt     = v1_r;
    v2_nxt     = v2_r;
    fl_idx_nxt = fl_idx_r;
    fl_end_nxt = fl_end_r;
    trail_nxt  = trail_r;
    pend_nxt   = pend_r;
    if (cmd.accept) begin
      fl_idx_nxt = AW'(1);
      fl_end_nxt = len_m1[AW-1:0];
      trail_nxt  = trail_c;
      pend_nxt   = in_byte;
      if (is_esc) begin
        len_nxt = LEN_ONE;
        sep_nxt = 1'b0;
        h1_nxt  = 1'b0;
        h2_nxt  = 1'b0;
        v1_nxt  = '0;
        v2_nxt  = '0;
      end else if (append) begin
        len_nxt = len_r + LEN_ONE;
        if (len_r != LEN_ONE) begin
          if (is_semi) begin
            sep_nxt = 1'b1;
          end else if (sep_r) begin
            h2_nxt = 1'b1;
            v2_nxt = sat_v;
          end else begin
            h1_nxt = 1'b1;
            v1_nxt = sat_v;
          end
        end
      end else begin
        len_nxt = LEN_ZERO;
      end
    end else if (cmd.idx_inc) begin
      fl_idx_nxt = fl_idx_r + AW'(1);
    end
  end

  aesp_ram #(
    .WIDTH (8),
    .DEPTH (SEQ_BUFFER_LEN)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r[AW-1:0]),
    .wdata (in_byte),
    .re    (cmd.rd_en),
    .raddr (fl_idx_r),
    .rdata (ram_rdata)
  );

  assign out_free = !ov_r || out_ready;

  always_comb begin
    ov_nxt  = ov_r;
    ok_nxt  = ok_r;
    ot_nxt  = ot_r;
    oc_nxt  = oc_r;
    oh1_nxt = oh1_r;
    oh2_nxt = oh2_r;
    ov1_nxt = ov1_r;
    ov2_nxt = ov2_r;
    ol_nxt  = ol_r;
    if (cmd.out_load) begin
      ov_nxt  = 1'b1;
      ok_nxt  = KIND_TEXT;
      ot_nxt  = '0;
      oc_nxt  = CMD_UP;
      oh1_nxt = 1'b0;
      oh2_nxt = 1'b0;
      ov1_nxt = '0;
      ov2_nxt = '0;
      ol_nxt  = 1'b1;
      case (cmd.out_src)
        SRC_IN: begin
          ot_nxt = in_byte;
        end
        SRC_CMD: begin
          ok_nxt  = KIND_CMD;
          oc_nxt  = fin_code;
          oh1_nxt = h1_r;
          oh2_nxt = h2_r;
          ov1_nxt = v1_r;
          ov2_nxt = v2_r;
        end
        SRC_RAM: begin
          ot_nxt = ram_rdata;
          ol_nxt = (fl_idx_r == fl_end_r) && !trail_r;
        end
        SRC_PEND: begin
          ot_nxt = pend_r;
        end
        default: begin
        end
      endcase
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_ZERO;
      sep_r <= 1'b0;
      h1_r  <= 1'b0;
      h2_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      len_r <= len_nxt;
      sep_r <= sep_nxt;
      h1_r  <= h1_nxt;
      h2_r  <= h2_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v1_r     <= v1_nxt;
    v2_r     <= v2_nxt;
    fl_idx_r <= fl_idx_nxt;
    fl_end_r <= fl_end_nxt;
    trail_r  <= trail_nxt;
    pend_r   <= pend_nxt;
    ok_r     <= ok_nxt;
    ot_r     <= ot_nxt;
    oc_r     <= oc_nxt;
    oh1_r    <= oh1_nxt;
    oh2_r    <= oh2_nxt;
    ov1_r    <= ov1_nxt;
    ov2_r    <= ov2_nxt;
    ol_r     <= ol_nxt;
  end

  assign sts.action   = action;
  assign sts.out_free = out_free;
  assign sts.fl_done  = (fl_idx_r == fl_end_r);
  assign sts.trail    = trail_r;

  assign out_valid = ov_r;
  assign out_kind  = ok_r;
  assign out_text  = ot_r;
  assign out_code  = oc_r;
  assign out_h1    = oh1_r;
  assign out_h2    = oh2_r;
  assign out_v1    = ov1_r;
  assign out_v2    = ov2_r;
  assign out_last  = ol_r;

endmodule

@@ hw/rtl/ansi_escape_sequence_parser.sv @@
// Top level of the ANSI escape sequence parser.
//
// The block decodes a terminal output stream. Bytes arrive one item at a time
// on in_ch; results leave on out_ch, either a text byte or a decoded CSI
// command (cursor moves, positioning, save and restore, erase, insert lines,
// attributes) with up to two decimal parameters saturated at 65535. One input
// item may cause no result, one result, or a run of results; last_of_run
// marks the final result caused by an item.
// A text byte or a completed command shows on out_ch in the cycle after its
// item is accepted, and such items can follow each other every cycle while
// out_ch does not stall. A flush of an invalid or overlong sequence replays
// the sequence buffer RAM through its single read port, with a read state and
// an emit state per replayed byte, then the trailing byte if there is one; no
// new item is taken until the run is out. The buffer holds SEQ_BUFFER_LEN bytes.
// When out_ch stalls, the held result stays unchanged in the output register
// and in_ch stops accepting until that register can be loaded again.
// Reset is synchronous and active low; it empties the sequence and drops any
// pending result. The buffer itself needs no clearing.
module ansi_escape_sequence_parser #(
  parameter int SEQ_BUFFER_LEN = 16
) (
  input logic        clk,
  input logic        rst_n,
  aesp_in_if.sink    in_ch,
  aesp_out_if.source out_ch
);
  import aesp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;

  // The controller sequences accepts and flush replays.
  aesp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath classifies bytes, keeps the sequence and drives results.
  aesp_dp #(
    .SEQ_BUFFER_LEN (SEQ_BUFFER_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_ch.data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_kind  (out_ch.item_kind),
    .out_text  (out_ch.text_byte),
    .out_code  (out_ch.command_code),
    .out_h1    (out_ch.has_first),
    .out_h2    (out_ch.has_second),
    .out_v1    (out_ch.first_value),
    .out_v2    (out_ch.second_value),
    .out_last  (out_ch.last_of_run)
  );

  assign in_ch.ready = in_ready;

endmodule

@@ hw/rtl/aesp_chk.sv @@
// Port-level assertions of the ANSI escape sequence parser and their binding.
module aesp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        item_kind,
  input logic [7:0]  text_byte,
  input logic [3:0]  command_code,
  input logic        has_first,
  input logic        has_second,
  input logic [15:0] first_value,
  input logic [15:0] second_value,
  input logic        last_of_run
);
  import aesp_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(text_byte) && $stable(item_kind)
      && $stable(command_code) && $stable(first_value) && $stable(second_value)
      && $stable(last_of_run))
    else $error("stalled result changed");

  a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_kind == KIND_CMD) |-> last_of_run && (command_code <= CMD_ATTR)
      && (has_first || (first_value == 16'd0)) && (has_second || (second_value == 16'd0)))
    else $error("malformed command result");

  a_text_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (item_kind == KIND_TEXT) |-> !has_first && !has_second
      && (first_value == 16'd0) && (second_value == 16'd0) && (command_code == CMD_UP))
    else $error("text result carries command fields");

endmodule

bind ansi_escape_sequence_parser aesp_chk u_aesp_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .item_kind    (out_ch.item_kind),
  .text_byte    (out_ch.text_byte),
  .command_code (out_ch.command_code),
  .has_first    (out_ch.has_first),
  .has_second   (out_ch.has_second),
  .first_value  (out_ch.first_value),
  .second_value (out_ch.second_value),
  .last_of_run  (out_ch.last_of_run)
);
